### hdl/word_pair_gap_stream_defines.svh
// Assertion macros shared by the checker of the word pair gap stream block.
// Depends on nothing; the including scope must provide clk and rst.
`ifndef WORD_PAIR_GAP_STREAM_DEFINES_SVH
`define WORD_PAIR_GAP_STREAM_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WGPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define WGPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/wgps_pkg.sv
// Shared types and constants of the word pair gap stream block.
// No dependencies; used by every module of the block.
package wgps_pkg;

  localparam int POS_WIDTH_DEFAULT = 24;
  localparam int CFG_WIDTH = 25;
  localparam logic [CFG_WIDTH-1:0] TOTAL_WORDS_RESET = CFG_WIDTH'(1);

  // Flag part of the per-stream state.
  typedef struct packed {
    logic pending_first;
    logic seen_first;
    logic seen_second;
    logic second_preceded;
  } flags_t;

  // Which results one word produces.
  typedef struct packed {
    logic pair;
    logic wrap;
  } res_t;

endpackage

### hdl/wgps_step.sv
// Combinational update for one word: new stream state and the gaps it yields.
// Depends on wgps_pkg.
module wgps_step #(
  parameter int POS_WIDTH = wgps_pkg::POS_WIDTH_DEFAULT
) (
  input  logic [POS_WIDTH-1:0] position,
  input  logic                 is_first_word,
  input  logic                 is_second_word,
  input  logic                 stream_end,
  input  wgps_pkg::flags_t     flags,
  input  logic [POS_WIDTH-1:0] latest_first_pos,
  input  logic [POS_WIDTH-1:0] earliest_second_pos,
  input  logic [POS_WIDTH:0]   total,
  output wgps_pkg::flags_t     flags_next,
  output logic [POS_WIDTH-1:0] latest_next,
  output logic [POS_WIDTH-1:0] earliest_next,
  output wgps_pkg::res_t       res,
  output logic [POS_WIDTH:0]   pair_gap,
  output logic [POS_WIDTH:0]   wrap_gap
);
  import wgps_pkg::*;

  logic                 first_b;
  flags_t               upd;
  logic [POS_WIDTH-1:0] latest_upd;
  logic [POS_WIDTH-1:0] earliest_upd;

  assign first_b = is_second_word && !flags.seen_second;

  // The B role of a word is handled before its A role.
  assign upd.pending_first   = is_first_word || (flags.pending_first && !is_second_word);
  assign upd.seen_first      = flags.seen_first || is_first_word;
  assign upd.seen_second     = flags.seen_second || is_second_word;
  assign upd.second_preceded = first_b ? flags.seen_first : flags.second_preceded;
  assign latest_upd   = is_first_word ? position : latest_first_pos;
  assign earliest_upd = first_b ? position : earliest_second_pos;

  assign res.pair = is_second_word && flags.pending_first;
  assign res.wrap = stream_end && upd.pending_first && upd.seen_second &&
                    !upd.second_preceded;

  assign pair_gap = {1'b0, position} - {1'b0, latest_first_pos};
  assign wrap_gap = total - {1'b0, latest_upd} + {1'b0, earliest_upd};

  // The stream state clears after its final word.
  assign flags_next    = stream_end ? '0 : upd;
  assign latest_next   = stream_end ? '0 : latest_upd;
  assign earliest_next = stream_end ? '0 : earliest_upd;

endmodule

### hdl/word_pair_gap_stream.sv
// Top level of the word pair gap stream block.
// Depends on wgps_pkg and wgps_step.
//
// Usage: words of the merged A/B occurrence stream enter on the input channel
// (in_valid/in_ready) in ascending position order; stream_end marks the final
// word. Gaps leave on the output channel (out_valid/out_ready), run_last set
// on the last result a word causes. total_words is written through its own
// channel (cfg_valid/cfg_ready, always ready); the user must write it only while the
// block is idle; the block itself does not enforce this. A word's first result is
// registered: the word passes the input register, then the result register.
// Throughput: one word per cycle while each word yields at most one result and the
// receiver keeps up; a word yielding a pair gap and a wrap gap shows the pair gap
// then the wrap gap. The result register holds one word's results, set by the single
// update stage. Reset empties both registers, clears the stream state and sets
// total_words to 1. When the receiver stalls, the result holds, a word with results
// waits in the input register, and in_ready drops until the result register drains.
module word_pair_gap_stream #(
  parameter int POS_WIDTH = wgps_pkg::POS_WIDTH_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wgps_pkg::CFG_WIDTH-1:0] total_words,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [POS_WIDTH-1:0]           position,
  input  logic                           is_first_word,
  input  logic                           is_second_word,
  input  logic                           stream_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [POS_WIDTH:0]             gap,
  output logic                           wrapped,
  output logic                           run_last
);
  import wgps_pkg::*;

  localparam int GapWidth = POS_WIDTH + 1;

  logic [CFG_WIDTH-1:0] total_q;

  // Input register.
  logic                 s1_valid;
  logic [POS_WIDTH-1:0] s1_pos;
  logic                 s1_a;
  logic                 s1_b;
  logic                 s1_last;

  // Stream state.
  flags_t               flags;
  logic [POS_WIDTH-1:0] latest_first_pos;
  logic [POS_WIDTH-1:0] earliest_second_pos;

  flags_t               flags_next;
  logic [POS_WIDTH-1:0] latest_next;
  logic [POS_WIDTH-1:0] earliest_next;
  res_t                 res;
  logic [GapWidth-1:0]  pair_gap;
  logic [GapWidth-1:0]  wrap_gap;

  // Result register: one word's results, shown one at a time.
  logic                 slot_valid;
  logic                 slot_idx;
  logic                 slot_two;
  logic [GapWidth-1:0]  r0_gap;
  logic                 r0_wrap;
  logic [GapWidth-1:0]  r1_gap;

  logic                 slot_done;
  logic                 has_res;
  logic                 s1_adv;

  wgps_step #(.POS_WIDTH(POS_WIDTH)) u_step (
    .position           (s1_pos),
    .is_first_word      (s1_a),
    .is_second_word     (s1_b),
    .stream_end         (s1_last),
    .flags              (flags),
    .latest_first_pos   (latest_first_pos),
    .earliest_second_pos(earliest_second_pos),
    .total              (GapWidth'(total_q)),
    .flags_next         (flags_next),
    .latest_next        (latest_next),
    .earliest_next      (earliest_next),
    .res                (res),
    .pair_gap           (pair_gap),
    .wrap_gap           (wrap_gap)
  );

  assign cfg_ready = 1'b1;

  assign out_valid = slot_valid;
  assign gap       = slot_idx ? r1_gap : r0_gap;
  assign wrapped   = slot_idx | r0_wrap;
  assign run_last  = slot_idx | !slot_two;

  assign slot_done = slot_valid && out_ready && run_last;
  assign has_res   = res.pair || res.wrap;
  // A word without results always moves on; one with results needs the slot.
  assign s1_adv    = s1_valid && (!has_res || !slot_valid || slot_done);
  assign in_ready  = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_q <= TOTAL_WORDS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      total_q <= total_words;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_pos  <= position;
      s1_a    <= is_first_word;
      s1_b    <= is_second_word;
      s1_last <= stream_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags               <= '0;
      latest_first_pos    <= '0;
      earliest_second_pos <= '0;
    end else if (s1_adv) begin
      flags               <= flags_next;
      latest_first_pos    <= latest_next;
      earliest_second_pos <= earliest_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      slot_idx   <= 1'b0;
      slot_two   <= 1'b0;
    end else if (s1_adv && has_res) begin
      slot_valid <= 1'b1;
      slot_idx   <= 1'b0;
      slot_two   <= res.pair && res.wrap;
    end else if (slot_done) begin
      slot_valid <= 1'b0;
      slot_idx   <= 1'b0;
    end else if (slot_valid && out_ready) begin
      slot_idx <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && has_res) begin
      r0_gap  <= res.pair ? pair_gap : wrap_gap;
      r0_wrap <= !res.pair;
      r1_gap  <= wrap_gap;
    end
  end

endmodule

### hdl/wgps_checker.sv
// Port-level checker of the word pair gap stream block, bound to its top level.
// Depends on word_pair_gap_stream_defines.svh, wgps_pkg and word_pair_gap_stream.
`include "word_pair_gap_stream_defines.svh"

module wgps_checker #(
  parameter int POS_WIDTH = wgps_pkg::POS_WIDTH_DEFAULT
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [POS_WIDTH:0]             gap,
  input logic                           wrapped,
  input logic                           run_last
);

  // No word is shown in the cycle right after reset.
  `WGPS_ASSERT_NOW(a_empty_after_reset, $past(rst), !out_valid, "result right after reset")

  // The wrap gap is always the final result of its word.
  `WGPS_ASSERT_NOW(a_wrap_is_last, out_valid && wrapped, run_last, "wrap gap not last")

  // A pair gap that is not the last result is followed by the wrap gap.
  `WGPS_ASSERT_NEXT(a_pair_then_wrap, out_valid && out_ready && !run_last,
                    out_valid && wrapped, "pair gap not followed by wrap gap")

  // A stalled result holds.
  `WGPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(gap) && $stable(wrapped) && $stable(run_last),
                    "stalled result changed")

endmodule

bind word_pair_gap_stream wgps_checker #(.POS_WIDTH(POS_WIDTH)) u_wgps_checker (.*);
